>>> sv/assert_macros.svh
// Assertion macros used by the RTL module.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check prop at every rising clk edge outside reset.
`define AHFR_ASSERT(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);

// Check that trig implies prop in the next cycle.
`define AHFR_ASSERT_NEXT(label, trig, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (trig) |=> (prop)) \
		else $error(msg);

`endif

>>> sv/ahfr_pkg.sv
// Constants, types and hex decode helpers for the ASCII hex frame receiver.
package ahfr_pkg;

	localparam int unsigned MAX_FRAME = 128;

	localparam int unsigned PADDR_W = 4;

	// register indexes (word address bits [3:2])
	localparam logic [1:0] REG_WRITE_TYPE = 2'd0;
	localparam logic [1:0] REG_READ_TYPE  = 2'd1;
	localparam logic [1:0] REG_CMD_TYPE   = 2'd2;

	localparam logic [7:0] WRITE_TYPE_RST = 8'd1;
	localparam logic [7:0] READ_TYPE_RST  = 8'd2;
	localparam logic [7:0] CMD_TYPE_RST   = 8'd3;

	// status codes
	localparam logic [2:0] ST_STORED   = 3'd0;
	localparam logic [2:0] ST_RESTART  = 3'd1;
	localparam logic [2:0] ST_ABORT    = 3'd2;
	localparam logic [2:0] ST_OVERFLOW = 3'd3;
	localparam logic [2:0] ST_COMPLETE = 3'd4;
	localparam logic [2:0] ST_IGNORED  = 3'd5;
	localparam logic [2:0] ST_TIMEOUT  = 3'd6;

	// request kinds
	localparam logic REQ_BYTE    = 1'b0;
	localparam logic REQ_TIMEOUT = 1'b1;

	// characters
	localparam logic [7:0] CH_COLON = 8'h3A;
	localparam logic [7:0] CH_LF    = 8'h0A;
	localparam logic [7:0] CH_CR    = 8'h0D;
	localparam logic [7:0] CH_4     = 8'h34;
	localparam logic [7:0] CH_5     = 8'h35;

	// frame layout
	localparam logic [7:0] POS_TYPE     = 8'd15;
	localparam logic [7:0] FIXED_LEN    = 8'd4;
	localparam logic [8:0] FRAME_OVHD   = 9'd20;
	localparam logic [8:0] LAST_OFFSET  = 9'd19;

	typedef struct packed {
		logic [2:0] status;
		logic [7:0] byte_index;
		logic [7:0] byte_echo;
		logic [7:0] frame_kind;
		logic [7:0] payload_length;
	} rsp_t;

	function automatic logic [3:0] hex_nibble(input logic [7:0] c);
		logic [7:0] v;
		v = 8'd0;
		if (c >= 8'h30 && c <= 8'h39) begin
			v = c - 8'h30;
		end else if (c >= 8'h41 && c <= 8'h46) begin
			v = c - 8'h37;
		end else if (c >= 8'h61 && c <= 8'h66) begin
			v = c - 8'h57;
		end
		return v[3:0];
	endfunction

	function automatic logic [7:0] hex_pair(input logic [7:0] hi, input logic [7:0] lo);
		return {hex_nibble(hi), hex_nibble(lo)};
	endfunction

endpackage

>>> sv/ascii_hex_frame_receiver.sv
// ASCII hex frame receiver: frames ':'-started, CR LF-ended packets one word at a time.
//
// Each accepted word (a received character or a timeout tick) yields one result word in the
// output stage. One word per cycle is taken back to back: the next frame state comes from
// combinational compare-and-count logic, and a two-entry output stage (result register plus
// skid register) keeps input accepted while one result waits. req_ready drops only when both
// output entries are full. Frame type codes are set over the APB port at 0x0, 0x4 and 0x8.
`include "assert_macros.svh"

module ascii_hex_frame_receiver (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              psel,
	input  logic                              penable,
	input  logic                              pwrite,
	input  logic [ahfr_pkg::PADDR_W-1:0]      paddr,
	input  logic [31:0]                       pwdata,
	output logic [31:0]                       prdata,
	output logic                              pready,
	input  logic                              req_valid,
	output logic                              req_ready,
	input  logic                              req_type,
	input  logic [7:0]                        rx_byte,
	output logic                              rsp_valid,
	input  logic                              rsp_ready,
	output logic [2:0]                        status,
	output logic [7:0]                        byte_index,
	output logic [7:0]                        byte_echo,
	output logic [7:0]                        frame_kind,
	output logic [7:0]                        payload_length
);

	logic [7:0] write_type_q, read_type_q, cmd_type_q;

	logic [7:0] position_q, position_d;
	logic [8:0] exp_size_q, exp_size_d;
	logic [7:0] length_q, length_d;
	logic [7:0] kind_q, kind_d;
	logic [7:0] caps_q [4];
	logic [7:0] caps_d [4];
	logic [7:0] last_q, last_d;
	logic       hold_q, hold_d;

	logic [8:0] next_pos;
	logic [7:0] pair_kind, pair_len;
	logic       do_clear;
	ahfr_pkg::rsp_t rsp_d, out_q, skid_q;
	logic       out_vld_q, skid_vld_q;
	logic       push, pop, cfg_wr;

	// ---------------- configuration ----------------
	assign pready = 1'b1;
	assign cfg_wr = psel & penable & pwrite & pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			write_type_q <= ahfr_pkg::WRITE_TYPE_RST;
			read_type_q  <= ahfr_pkg::READ_TYPE_RST;
			cmd_type_q   <= ahfr_pkg::CMD_TYPE_RST;
		end else if (cfg_wr) begin
			unique case (paddr[3:2])
				ahfr_pkg::REG_WRITE_TYPE: write_type_q <= pwdata[7:0];
				ahfr_pkg::REG_READ_TYPE:  read_type_q  <= pwdata[7:0];
				ahfr_pkg::REG_CMD_TYPE:   cmd_type_q   <= pwdata[7:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (paddr[3:2])
			ahfr_pkg::REG_WRITE_TYPE: prdata = {24'd0, write_type_q};
			ahfr_pkg::REG_READ_TYPE:  prdata = {24'd0, read_type_q};
			ahfr_pkg::REG_CMD_TYPE:   prdata = {24'd0, cmd_type_q};
			default:                  prdata = 32'd0;
		endcase
	end

	// ---------------- handshake ----------------
	assign req_ready = !skid_vld_q;
	assign push      = req_valid & req_ready;
	assign pop       = out_vld_q & rsp_ready;

	// ---------------- frame step ----------------
	assign next_pos  = {1'b0, position_q} + 9'd1;
	assign pair_kind = ahfr_pkg::hex_pair(caps_q[2], caps_q[3]);
	assign pair_len  = ahfr_pkg::hex_pair(last_q, rx_byte);

	always_comb begin
		position_d = position_q;
		exp_size_d = exp_size_q;
		length_d   = length_q;
		kind_d     = kind_q;
		caps_d     = caps_q;
		last_d     = last_q;
		hold_d     = hold_q;
		do_clear   = 1'b0;
		rsp_d.status     = ahfr_pkg::ST_STORED;
		rsp_d.byte_index = 8'd0;
		rsp_d.byte_echo  = 8'd0;

		if (req_type == ahfr_pkg::REQ_TIMEOUT) begin
			do_clear     = 1'b1;
			hold_d       = 1'b0;
			rsp_d.status = ahfr_pkg::ST_TIMEOUT;
		end else if (hold_q) begin
			rsp_d.status = ahfr_pkg::ST_IGNORED;
		end else begin
			rsp_d.byte_index = position_q;
			rsp_d.byte_echo  = rx_byte;
			if (rx_byte == ahfr_pkg::CH_COLON && position_q != 8'd0) begin
				rsp_d.byte_index = 8'd0;
				rsp_d.status     = ahfr_pkg::ST_RESTART;
			end else begin
				case (position_q)
					8'd0: caps_d[0] = rx_byte;
					8'd1: caps_d[1] = rx_byte;
					8'd8: caps_d[2] = rx_byte;
					8'd9: caps_d[3] = rx_byte;
					default: ;
				endcase
				if (position_q == ahfr_pkg::POS_TYPE) begin
					kind_d = pair_kind;
					if (pair_kind == write_type_q) begin
						length_d   = pair_len;
						exp_size_d = ahfr_pkg::FRAME_OVHD + {1'b0, pair_len};
					end else if (pair_kind == read_type_q || pair_kind == cmd_type_q) begin
						length_d   = ahfr_pkg::FIXED_LEN;
						exp_size_d = ahfr_pkg::FRAME_OVHD + {1'b0, ahfr_pkg::FIXED_LEN};
					end
				end
				// LF only belongs in the last slot of a frame of known size
				if (rx_byte == ahfr_pkg::CH_LF &&
				    (exp_size_d == 9'd0 || {1'b0, position_q} != exp_size_d - 9'd1)) begin
					do_clear     = 1'b1;
					rsp_d.status = ahfr_pkg::ST_ABORT;
				end else if (position_q != 8'd0 &&
				             {1'b0, position_q} == ahfr_pkg::LAST_OFFSET + {1'b0, length_d} &&
				             caps_d[0] == ahfr_pkg::CH_COLON &&
				             (caps_d[1] == ahfr_pkg::CH_4 || caps_d[1] == ahfr_pkg::CH_5) &&
				             last_q == ahfr_pkg::CH_CR && rx_byte == ahfr_pkg::CH_LF) begin
					hold_d       = 1'b1;
					last_d       = rx_byte;
					rsp_d.status = ahfr_pkg::ST_COMPLETE;
				end else begin
					last_d = rx_byte;
					if (next_pos >= 9'(ahfr_pkg::MAX_FRAME)) begin
						do_clear     = 1'b1;
						rsp_d.status = ahfr_pkg::ST_OVERFLOW;
					end else begin
						position_d = next_pos[7:0];
					end
				end
			end
		end

		if (do_clear || rsp_d.status == ahfr_pkg::ST_RESTART) begin
			position_d = 8'd0;
			exp_size_d = 9'd0;
			caps_d[0]  = 8'd0;
			caps_d[1]  = 8'd0;
			caps_d[2]  = 8'd0;
			caps_d[3]  = 8'd0;
			last_d     = 8'd0;
		end
		// restart keeps the new ':' as the first character
		if (rsp_d.status == ahfr_pkg::ST_RESTART) begin
			caps_d[0]  = rx_byte;
			last_d     = rx_byte;
			position_d = 8'd1;
		end

		rsp_d.frame_kind     = kind_d;
		rsp_d.payload_length = length_d;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			position_q <= 8'd0;
			exp_size_q <= 9'd0;
			length_q   <= 8'd0;
			kind_q     <= 8'd0;
			caps_q     <= '{default: 8'd0};
			last_q     <= 8'd0;
			hold_q     <= 1'b0;
		end else if (push) begin
			position_q <= position_d;
			exp_size_q <= exp_size_d;
			length_q   <= length_d;
			kind_q     <= kind_d;
			caps_q     <= caps_d;
			last_q     <= last_d;
			hold_q     <= hold_d;
		end
	end

	// ---------------- output stage ----------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld_q  <= 1'b0;
			skid_vld_q <= 1'b0;
		end else begin
			if (pop && skid_vld_q) begin
				skid_vld_q <= 1'b0;
			end else if (push) begin
				if (!out_vld_q || pop) begin
					out_vld_q <= 1'b1;
				end else begin
					skid_vld_q <= 1'b1;
				end
			end else if (pop) begin
				out_vld_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (pop && skid_vld_q) begin
			out_q <= skid_q;
		end else if (push) begin
			if (!out_vld_q || pop) begin
				out_q <= rsp_d;
			end else begin
				skid_q <= rsp_d;
			end
		end
	end

	assign rsp_valid      = out_vld_q;
	assign status         = out_q.status;
	assign byte_index     = out_q.byte_index;
	assign byte_echo      = out_q.byte_echo;
	assign frame_kind     = out_q.frame_kind;
	assign payload_length = out_q.payload_length;

	// ---------------- checks ----------------
	`AHFR_ASSERT(a_skid_behind_out, !skid_vld_q || out_vld_q, "skid word without result word")
	`AHFR_ASSERT(a_pos_in_range, {1'b0, position_q} < 9'(ahfr_pkg::MAX_FRAME), "position overflow")
	`AHFR_ASSERT_NEXT(a_complete_holds, push && rsp_d.status == ahfr_pkg::ST_COMPLETE, hold_q, "complete frame not holding")
	`AHFR_ASSERT_NEXT(a_timeout_clears, push && req_type == ahfr_pkg::REQ_TIMEOUT, position_q == 8'd0 && !hold_q && exp_size_q == 9'd0, "timeout did not clear frame")

endmodule

>>> sim/tb.sv
// Testbench for ascii_hex_frame_receiver: directed table, random framed traffic, scoreboard.
module tb;
	timeunit 1ns;
	timeprecision 1ps;

	localparam logic [7:0] CH_0 = 8'h30;
	localparam logic [7:0] CH_1 = 8'h31;
	localparam int unsigned WORDS_PER_PHASE = 175;
	localparam int unsigned HOLD_OFF_CYCLES = 300;
	localparam int unsigned MAX_PRINTED = 40;

	typedef struct packed {
		logic rq;
		logic [7:0] c;
		logic lit;
		ahfr_pkg::rsp_t want;
	} stim_row_t;

	typedef enum int {
		SH_GOOD,
		SH_BAD_CH1,
		SH_NO_CR,
		SH_NONHEX_TYPE,
		SH_TRUNC,
		SH_EARLY_LF,
		SH_NO_COLON
	} frame_shape_t;

	logic clk;
	logic arst_n;
	logic psel;
	logic penable;
	logic pwrite;
	logic [ahfr_pkg::PADDR_W-1:0] paddr;
	logic [31:0] pwdata;
	logic [31:0] prdata;
	logic pready;
	logic req_valid;
	logic req_ready;
	logic req_type;
	logic [7:0] rx_byte;
	logic rsp_valid;
	logic rsp_ready;
	logic [2:0] status;
	logic [7:0] byte_index;
	logic [7:0] byte_echo;
	logic [7:0] frame_kind;
	logic [7:0] payload_length;

	ascii_hex_frame_receiver dut (
		.clk(clk),
		.arst_n(arst_n),
		.psel(psel),
		.penable(penable),
		.pwrite(pwrite),
		.paddr(paddr),
		.pwdata(pwdata),
		.prdata(prdata),
		.pready(pready),
		.req_valid(req_valid),
		.req_ready(req_ready),
		.req_type(req_type),
		.rx_byte(rx_byte),
		.rsp_valid(rsp_valid),
		.rsp_ready(rsp_ready),
		.status(status),
		.byte_index(byte_index),
		.byte_echo(byte_echo),
		.frame_kind(frame_kind),
		.payload_length(payload_length)
	);

	// framer copy: type codes and frame state
	logic [7:0] wr_code;
	logic [7:0] rd_code;
	logic [7:0] cmd_code;
	logic [7:0] pos;
	logic [8:0] exp_size;
	logic [7:0] len_q;
	logic [7:0] kind_q;
	logic [7:0] cap [4];
	logic [7:0] prev_char;
	logic held;

	ahfr_pkg::rsp_t pending_results [$];
	logic [7:0] frame_buf [$];
	stim_row_t dir_tab [0:24];
	int unsigned mismatches = 0;
	int unsigned words_done = 0;
	int unsigned status_seen [8];
	bit burst = 1'b0;

	int unsigned hold_requests = 0;
	int unsigned hold_served = 0;
	int unsigned hold_left = 0;
	int unsigned rx_run = 0;
	bit rx_on = 1'b0;

	initial clk = 1'b0;
	always #5 clk = ~clk;

	initial begin
		#5_000_000;
		$display("** ascii_hex_frame_receiver: FAILED **");
		$finish;
	end

	task automatic note_mismatch(input string msg);
		mismatches++;
		if (mismatches <= MAX_PRINTED) begin
			$display("MISMATCH at %0t: %s", $time, msg);
		end
	endtask

	task automatic check_field(input string name, input int got, input int want);
		if (got != want) begin
			note_mismatch($sformatf("%s got %0d, predicted %0d", name, got, want));
		end
	endtask

	function automatic logic [3:0] nib(input logic [7:0] c);
		logic [7:0] d;
		d = 8'd0;
		if (c inside {[8'h30:8'h39]}) begin
			d = c - 8'h30;
		end else if (c inside {[8'h41:8'h46]}) begin
			d = c - 8'h41 + 8'd10;
		end else if (c inside {[8'h61:8'h66]}) begin
			d = c - 8'h61 + 8'd10;
		end
		return d[3:0];
	endfunction

	function automatic logic [7:0] pair_value(input logic [7:0] hi, input logic [7:0] lo);
		return {nib(hi), nib(lo)};
	endfunction

	function automatic void clear_frame();
		pos = 8'd0;
		exp_size = 9'd0;
		foreach (cap[i]) cap[i] = 8'd0;
		prev_char = 8'd0;
	endfunction

	// one accepted word through the framer copy; returns the result it must produce
	function automatic ahfr_pkg::rsp_t advance_framer(input logic rq, input logic [7:0] c);
		ahfr_pkg::rsp_t r;
		r = '0;
		if (rq == ahfr_pkg::REQ_TIMEOUT) begin
			clear_frame();
			held = 1'b0;
			r.status = ahfr_pkg::ST_TIMEOUT;
		end else if (held) begin
			r.status = ahfr_pkg::ST_IGNORED;
		end else begin
			r.byte_index = pos;
			r.byte_echo = c;
			if (c == ahfr_pkg::CH_COLON && pos != 8'd0) begin
				clear_frame();
				cap[0] = c;
				prev_char = c;
				pos = 8'd1;
				r.byte_index = 8'd0;
				r.status = ahfr_pkg::ST_RESTART;
			end else begin
				case (pos)
					8'd0: cap[0] = c;
					8'd1: cap[1] = c;
					8'd8: cap[2] = c;
					8'd9: cap[3] = c;
					default: ;
				endcase
				if (pos == ahfr_pkg::POS_TYPE) begin
					kind_q = pair_value(cap[2], cap[3]);
					// write match wins over read and command
					if (kind_q == wr_code) begin
						len_q = pair_value(prev_char, c);
						exp_size = ahfr_pkg::FRAME_OVHD + {1'b0, len_q};
					end else if (kind_q == rd_code || kind_q == cmd_code) begin
						len_q = ahfr_pkg::FIXED_LEN;
						exp_size = ahfr_pkg::FRAME_OVHD + {1'b0, len_q};
					end
				end
				if (c == ahfr_pkg::CH_LF && int'(pos) != int'(exp_size) - 1) begin
					clear_frame();
					r.status = ahfr_pkg::ST_ABORT;
				end else if (pos != 8'd0 &&
						int'(pos) == int'(ahfr_pkg::LAST_OFFSET) + int'(len_q) &&
						cap[0] == ahfr_pkg::CH_COLON &&
						(cap[1] == ahfr_pkg::CH_4 || cap[1] == ahfr_pkg::CH_5) &&
						prev_char == ahfr_pkg::CH_CR && c == ahfr_pkg::CH_LF) begin
					held = 1'b1;
					prev_char = c;
					r.status = ahfr_pkg::ST_COMPLETE;
				end else begin
					prev_char = c;
					if (int'(pos) + 1 >= int'(ahfr_pkg::MAX_FRAME)) begin
						clear_frame();
						r.status = ahfr_pkg::ST_OVERFLOW;
					end else begin
						pos = pos + 8'd1;
						r.status = ahfr_pkg::ST_STORED;
					end
				end
			end
		end
		r.frame_kind = kind_q;
		r.payload_length = len_q;
		return r;
	endfunction

	function automatic int gap_len();
		int r;
		r = $urandom_range(0, 99);
		if (r < 55) return 0;
		if (r < 85) return $urandom_range(1, 3);
		if (r < 97) return $urandom_range(4, 12);
		return $urandom_range(20, 60);
	endfunction

	function automatic logic [7:0] hex_char(input logic [3:0] n);
		if (n < 4'd10) return CH_0 + n;
		return ($urandom_range(0, 1) ? 8'h41 : 8'h61) + n - 8'd10;
	endfunction

	function automatic logic [7:0] rand_hex();
		return hex_char(4'($urandom_range(0, 15)));
	endfunction

	function automatic logic [7:0] safe_noise();
		logic [7:0] c;
		do begin
			c = 8'($urandom_range(0, 255));
		end while (c == ahfr_pkg::CH_COLON || c == ahfr_pkg::CH_LF);
		return c;
	endfunction

	// hold the word on the bus until the block takes it, then log the prediction
	task automatic send_word(input logic rq, input logic [7:0] c, input logic lit,
			input ahfr_pkg::rsp_t want);
		int g;
		ahfr_pkg::rsp_t pred;
		g = burst ? 0 : gap_len();
		if (g != 0) begin
			req_valid <= 1'b0;
			repeat (g) @(posedge clk);
		end
		req_valid <= 1'b1;
		req_type <= rq;
		rx_byte <= c;
		@(posedge clk);
		while (!req_ready) @(posedge clk);
		pred = advance_framer(rq, c);
		status_seen[pred.status]++;
		if (pred.status != ahfr_pkg::ST_IGNORED) words_done++;
		pending_results.push_back(lit ? want : pred);
	endtask

	task automatic send_timeout();
		send_word(ahfr_pkg::REQ_TIMEOUT, 8'($urandom_range(0, 255)), 1'b0, '0);
	endtask

	task automatic send_buf();
		foreach (frame_buf[i]) send_word(ahfr_pkg::REQ_BYTE, frame_buf[i], 1'b0, '0);
	endtask

	// drop valid and wait until every result is back
	task automatic settle();
		req_valid <= 1'b0;
		while (pending_results.size() != 0) @(posedge clk);
	endtask

	task automatic apb_write(input logic [1:0] idx, input logic [7:0] value);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= {idx, 2'b00};
		pwdata <= {24'd0, value};
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready) @(posedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		case (idx)
			ahfr_pkg::REG_WRITE_TYPE: wr_code = value;
			ahfr_pkg::REG_READ_TYPE: rd_code = value;
			ahfr_pkg::REG_CMD_TYPE: cmd_code = value;
			default: ;
		endcase
	endtask

	// build a frame with random content, then damage it according to shape
	function automatic void make_frame(input frame_shape_t shape);
		logic [7:0] code;
		logic [7:0] lenb;
		int n;
		int sel;
		int j;
		sel = $urandom_range(0, 99);
		if (sel < 80) lenb = 8'($urandom_range(0, 12));
		else if (sel < 95) lenb = 8'($urandom_range(13, 40));
		else lenb = 8'($urandom_range(100, 255));
		case ($urandom_range(0, 3))
			0: code = wr_code;
			1: code = rd_code;
			2: code = cmd_code;
			default: code = 8'($urandom_range(0, 255));
		endcase
		if (code == wr_code) n = lenb;
		else if (code == rd_code || code == cmd_code) n = ahfr_pkg::FIXED_LEN;
		else n = $urandom_range(0, 8);
		frame_buf.delete();
		frame_buf.push_back(ahfr_pkg::CH_COLON);
		frame_buf.push_back($urandom_range(0, 1) ? ahfr_pkg::CH_4 : ahfr_pkg::CH_5);
		repeat (6) frame_buf.push_back(rand_hex());
		frame_buf.push_back(hex_char(code[7:4]));
		frame_buf.push_back(hex_char(code[3:0]));
		repeat (4) frame_buf.push_back(rand_hex());
		frame_buf.push_back(hex_char(lenb[7:4]));
		frame_buf.push_back(hex_char(lenb[3:0]));
		repeat (2) frame_buf.push_back(rand_hex());
		repeat (n) frame_buf.push_back(rand_hex());
		frame_buf.push_back(ahfr_pkg::CH_CR);
		frame_buf.push_back(ahfr_pkg::CH_LF);
		case (shape)
			SH_BAD_CH1: frame_buf[1] = rand_hex();
			SH_NO_CR: frame_buf[frame_buf.size() - 2] = rand_hex();
			SH_NONHEX_TYPE: begin
				frame_buf[8] = safe_noise();
				frame_buf[9] = safe_noise();
			end
			SH_TRUNC: repeat ($urandom_range(1, frame_buf.size() - 2)) void'(frame_buf.pop_back());
			SH_EARLY_LF: begin
				j = $urandom_range(1, frame_buf.size() - 2);
				frame_buf.insert(j, ahfr_pkg::CH_LF);
			end
			SH_NO_COLON: frame_buf[0] = rand_hex();
			default: ;
		endcase
	endfunction

	task automatic run_episode();
		int r;
		frame_shape_t shape;
		r = $urandom_range(0, 99);
		burst = ($urandom_range(0, 3) == 0);
		if (r < 86) begin
			if (r < 55) shape = SH_GOOD;
			else if (r < 60) shape = SH_BAD_CH1;
			else if (r < 64) shape = SH_NO_CR;
			else if (r < 68) shape = SH_NONHEX_TYPE;
			else if (r < 76) shape = SH_TRUNC;
			else if (r < 83) shape = SH_EARLY_LF;
			else shape = SH_NO_COLON;
			make_frame(shape);
			send_buf();
			// release a held frame, with a few stray bytes first
			if (shape != SH_TRUNC && $urandom_range(0, 99) < 85) begin
				repeat ($urandom_range(0, 2)) send_word(ahfr_pkg::REQ_BYTE,
						8'($urandom_range(0, 255)), 1'b0, '0);
				send_timeout();
			end
		end else if (r < 92) begin
			repeat ($urandom_range(1, 20)) send_word(ahfr_pkg::REQ_BYTE,
					8'($urandom_range(0, 255)), 1'b0, '0);
		end else if (r < 95) begin
			// run past the frame limit
			if ($urandom_range(0, 1)) send_timeout();
			frame_buf.delete();
			repeat (ahfr_pkg::MAX_FRAME + 2) frame_buf.push_back(safe_noise());
			send_buf();
		end else begin
			send_timeout();
		end
	endtask

	// receiver: alternating ready and stall runs, plus the long hold-off on request
	always @(posedge clk) begin
		if (hold_served != hold_requests) begin
			hold_served = hold_requests;
			hold_left = HOLD_OFF_CYCLES;
		end
		if (hold_left != 0) begin
			hold_left--;
			rsp_ready <= 1'b0;
		end else begin
			if (rx_run == 0) begin
				rx_on = !rx_on;
				rx_run = rx_on ? $urandom_range(1, 40) : 1 + gap_len();
			end
			rx_run--;
			rsp_ready <= rx_on;
		end
	end

	always @(posedge clk) begin : result_check
		ahfr_pkg::rsp_t e;
		if (arst_n && rsp_valid && rsp_ready) begin
			if (pending_results.size() == 0) begin
				note_mismatch($sformatf("result with nothing pending: status %0d index %0d",
						status, byte_index));
			end else begin
				e = pending_results.pop_front();
				check_field("status", status, e.status);
				check_field("byte_index", byte_index, e.byte_index);
				check_field("byte_echo", byte_echo, e.byte_echo);
				check_field("frame_kind", frame_kind, e.frame_kind);
				check_field("payload_length", payload_length, e.payload_length);
			end
		end
	end

	initial begin
		logic [7:0] codes [3];
		int unsigned phase_start;
		arst_n = 1'b0;
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		paddr = '0;
		pwdata = '0;
		req_valid = 1'b0;
		req_type = ahfr_pkg::REQ_BYTE;
		rx_byte = 8'd0;
		rsp_ready = 1'b0;
		foreach (status_seen[i]) status_seen[i] = 0;
		wr_code = ahfr_pkg::WRITE_TYPE_RST;
		rd_code = ahfr_pkg::READ_TYPE_RST;
		cmd_code = ahfr_pkg::CMD_TYPE_RST;
		len_q = 8'd0;
		kind_q = 8'd0;
		held = 1'b0;
		clear_frame();

		// after reset: timeout, abort, restart, then a write frame (length 0) that completes
		dir_tab = '{
			'{ahfr_pkg::REQ_TIMEOUT, 8'hFF, 1'b1,
				'{ahfr_pkg::ST_TIMEOUT, 8'd0, 8'd0, 8'd0, 8'd0}},
			'{ahfr_pkg::REQ_BYTE, ahfr_pkg::CH_LF, 1'b1,
				'{ahfr_pkg::ST_ABORT, 8'd0, ahfr_pkg::CH_LF, 8'd0, 8'd0}},
			'{ahfr_pkg::REQ_BYTE, 8'hFF, 1'b1,
				'{ahfr_pkg::ST_STORED, 8'd0, 8'hFF, 8'd0, 8'd0}},
			'{ahfr_pkg::REQ_BYTE, ahfr_pkg::CH_COLON, 1'b1,
				'{ahfr_pkg::ST_RESTART, 8'd0, ahfr_pkg::CH_COLON, 8'd0, 8'd0}},
			'{ahfr_pkg::REQ_BYTE, ahfr_pkg::CH_4, 1'b0, '0},
			'{ahfr_pkg::REQ_BYTE, CH_0, 1'b0, '0},
			'{ahfr_pkg::REQ_BYTE, CH_0, 1'b0, '0},
			'{ahfr_pkg::REQ_BYTE, CH_0, 1'b0, '0},
			'{ahfr_pkg::REQ_BYTE, CH_0, 1'b0, '0},
			'{ahfr_pkg::REQ_BYTE, CH_0, 1'b0, '0},
			'{ahfr_pkg::REQ_BYTE, CH_0, 1'b0, '0},
			'{ahfr_pkg::REQ_BYTE, CH_0, 1'b0, '0},
			'{ahfr_pkg::REQ_BYTE, CH_1, 1'b0, '0},
			'{ahfr_pkg::REQ_BYTE, CH_0, 1'b0, '0},
			'{ahfr_pkg::REQ_BYTE, CH_0, 1'b0, '0},
			'{ahfr_pkg::REQ_BYTE, CH_0, 1'b0, '0},
			'{ahfr_pkg::REQ_BYTE, CH_0, 1'b0, '0},
			'{ahfr_pkg::REQ_BYTE, CH_0, 1'b0, '0},
			'{ahfr_pkg::REQ_BYTE, CH_0, 1'b0, '0},
			'{ahfr_pkg::REQ_BYTE, CH_0, 1'b0, '0},
			'{ahfr_pkg::REQ_BYTE, CH_0, 1'b0, '0},
			'{ahfr_pkg::REQ_BYTE, ahfr_pkg::CH_CR, 1'b0, '0},
			'{ahfr_pkg::REQ_BYTE, ahfr_pkg::CH_LF, 1'b1,
				'{ahfr_pkg::ST_COMPLETE, 8'd19, ahfr_pkg::CH_LF, 8'd1, 8'd0}},
			'{ahfr_pkg::REQ_BYTE, 8'h00, 1'b1,
				'{ahfr_pkg::ST_IGNORED, 8'd0, 8'd0, 8'd1, 8'd0}},
			'{ahfr_pkg::REQ_TIMEOUT, 8'h00, 1'b1,
				'{ahfr_pkg::ST_TIMEOUT, 8'd0, 8'd0, 8'd1, 8'd0}}
		};

		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (dir_tab[i]) send_word(dir_tab[i].rq, dir_tab[i].c, dir_tab[i].lit,
				dir_tab[i].want);

		for (int ph = 0; ph < 4; ph++) begin
			settle();
			case (ph)
				0: codes = '{8'hFF, 8'h00, 8'h7E};
				1: codes = '{8'h10, 8'h10, 8'h20};
				2: begin
					codes[0] = 8'($urandom_range(0, 255));
					codes[1] = 8'($urandom_range(0, 255));
					codes[2] = codes[1];
				end
				default: codes = '{8'hA5, 8'hFF, 8'h00};
			endcase
			apb_write(ahfr_pkg::REG_WRITE_TYPE, codes[0]);
			apb_write(ahfr_pkg::REG_READ_TYPE, codes[1]);
			apb_write(ahfr_pkg::REG_CMD_TYPE, codes[2]);
			// starve the output so the block backs up into its input
			if (ph == 0 || ph == 2) hold_requests++;
			phase_start = words_done;
			while (words_done - phase_start < WORDS_PER_PHASE) run_episode();
		end

		settle();
		repeat (8) @(posedge clk);
		$display("Covered %0d words over five type-code settings: %0d frames complete,",
				words_done, status_seen[ahfr_pkg::ST_COMPLETE]);
		$display("%0d restarts, %0d aborts, %0d overflow clears, %0d timeouts, %0d dropped; %0d mismatches.",
				status_seen[ahfr_pkg::ST_RESTART], status_seen[ahfr_pkg::ST_ABORT],
				status_seen[ahfr_pkg::ST_OVERFLOW], status_seen[ahfr_pkg::ST_TIMEOUT],
				status_seen[ahfr_pkg::ST_IGNORED], mismatches);
		if (mismatches == 0 && pending_results.size() == 0) begin
			$display("** ascii_hex_frame_receiver: PASSED **");
		end else begin
			$display("** ascii_hex_frame_receiver: FAILED **");
		end
		$finish;
	end

endmodule
